// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

// ===== hdl/ftrt_pkg.sv =====
package ftrt_pkg;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_TCP   = 2'd1;
    localparam logic [1:0] KIND_UDP   = 2'd2;
    localparam logic REG_FILTER_ENABLE = 1'b0;
    localparam logic REG_FILTER_PORT   = 1'b1;
    localparam int KEY_W = 97;
    localparam int ENTRY_W = KEY_W + 32;

    typedef enum logic [2:0] {
        t_IDLE, t_SEARCH, t_WAIT, t_CHECK, t_DONE, t_OUT
    } t_state;

    // search unit control
    typedef struct packed {
        logic start;
    } t_srch_ctl;

    typedef struct packed {
        logic busy;
        logic done;
        logic found;
    } t_srch_sts;
endpackage

// ===== hdl/ftrt_ram.sv =====
module ftrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/ftrt_search.sv =====
// Walks the used entries one per cycle, comparing each key with a single comparator
module ftrt_search import ftrt_pkg::*; #(
    parameter int AW = 8,
    parameter int CW = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_srch_ctl          i_ctl,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [CW-1:0]      i_used,
    input  logic [ENTRY_W-1:0] i_rdata,
    output logic [AW-1:0]      o_raddr,
    output t_srch_sts          o_sts,
    output logic [31:0]        o_next_seq
);
    logic [CW-1:0] r_issue, n_issue;
    logic [CW-1:0] r_check, n_check;
    logic          r_rd_v, n_rd_v;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic          r_found, n_found;
    logic [31:0]   r_seq, n_seq;
    logic          w_hit;

    assign w_hit = r_rd_v && (i_rdata[ENTRY_W-1:32] == i_key);
    assign o_raddr = r_issue[AW-1:0];

    // issue one read a cycle, compare one registered read a cycle
    always_comb begin
        n_issue = r_issue;
        n_check = r_check;
        n_rd_v  = 1'b0;
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_found = r_found;
        n_seq   = r_seq;
        if (i_ctl.start) begin
            n_issue = '0;
            n_check = '0;
            n_busy  = 1'b1;
            n_found = 1'b0;
        end else if (r_busy) begin
            if (w_hit) begin
                n_busy  = 1'b0;
                n_done  = 1'b1;
                n_found = 1'b1;
                n_seq   = i_rdata[31:0];
            end else if (r_check >= i_used) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                if (r_issue < i_used) begin
                    n_rd_v  = 1'b1;
                    n_issue = r_issue + 1'b1;
                end
                if (r_rd_v) begin
                    n_check = r_check + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_rd_v  <= 1'b0;
            r_found <= 1'b0;
            r_issue <= '0;
            r_check <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_rd_v  <= n_rd_v;
            r_found <= n_found;
            r_issue <= n_issue;
            r_check <= n_check;
        end
        r_seq   <= n_seq;
    end

    assign o_sts.busy  = r_busy;
    assign o_sts.done  = r_done;
    assign o_sts.found = r_found;
    assign o_next_seq  = r_seq;

    `include "assert_macros.svh"
    `ASSERT_CLK(a_done_one, i_clk, i_rst_n, r_done |=> !r_done, "done held")
    `ASSERT_CLK(a_not_both, i_clk, i_rst_n, !(r_done && r_busy), "done while busy")
    `ASSERT_CLK(a_chk_le, i_clk, i_rst_n, r_check <= r_issue, "check ahead of issue")
endmodule

// ===== hdl/flow_table_retransmit_tracker.sv =====
// Channel | Dir | Contents
// s_axis  | in  | one parsed packet header
// m_axis  | out | one result per packet
// cfg     | in  | filter_enable (0), filter_port (1)
// The search unit reads the flow RAM one entry per cycle through its read
// port, walking at most the used entries (up to FLOW_ENTRIES) per packet.
// Only one packet is in flight; s_axis_tready is low from accept until the
// result is taken. Reset is synchronous; entries are tracked by a fill count,
// so no clearing pass is needed. The result holds while m_axis_tready is low.
module flow_table_retransmit_tracker import ftrt_pkg::*; #(
    parameter int FLOW_ENTRIES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // protocol[7:0], src_addr[39:8], dst_addr[71:40], sport[87:72],
    // dst_port[103:88], frame_length[119:104], ip_header_words[123:120],
    // seq_number[155:124], syn[156], fin[157], rst[158], zero fill
    input  logic [159:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // packet_kind[1:0], passed_filter[2], retransmit[3], new_flow[4],
    // table_full[5], payload[21:6], tcp_packet_total[53:22],
    // udp_packet_total[85:54], tcp_byte_total[117:86], udp_byte_total[149:118],
    // tcp_flow_total[158:150], udp_flow_total[167:159], zero fill
    output logic [175:0]  m_axis_tdata,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [15:0]   i_cfg_data
);
    localparam int AW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CW = $clog2(FLOW_ENTRIES + 1);

    t_state r_state, n_state;
    logic   r_fen;
    logic [15:0] r_fport;
    logic [159:0] r_in;
    logic [CW-1:0] r_used;
    logic [31:0] r_tcp_p, r_udp_p, r_tcp_b, r_udp_b;
    logic [8:0]  r_tcp_f, r_udp_f;
    logic [1:0]  r_kind;
    logic        r_pass, r_retx, r_new, r_full;
    logic [15:0] r_pay;

    logic [7:0]  w_proto;
    logic [31:0] w_sa, w_da, w_seq;
    logic [15:0] w_sp, w_dp, w_flen;
    logic [3:0]  w_ihl;
    logic        w_syn, w_fin, w_rst, w_udp, w_track;
    logic [17:0] w_sub;
    logic [15:0] w_pay;
    logic [KEY_W-1:0] w_key;
    logic        w_keep, w_retx, w_ins;
    logic [31:0] w_diff;

    t_srch_ctl   w_ctl;
    t_srch_sts   w_sts;
    logic [AW-1:0] w_raddr;
    logic [ENTRY_W-1:0] w_rdata;
    logic [31:0] w_nseq;

    assign w_proto = r_in[7:0];
    assign w_sa    = r_in[39:8];
    assign w_da    = r_in[71:40];
    assign w_sp    = r_in[87:72];
    assign w_dp    = r_in[103:88];
    assign w_flen  = r_in[119:104];
    assign w_ihl   = r_in[123:120];
    assign w_seq   = r_in[155:124];
    assign w_syn   = r_in[156];
    assign w_fin   = r_in[157];
    assign w_rst   = r_in[158];
    assign w_udp   = (w_proto == PROTO_UDP);
    assign w_key   = {w_sa, w_da, w_sp, w_dp, w_udp};
    assign w_track = !r_fen || w_sp == r_fport || w_dp == r_fport;

    // payload with saturation at zero
    assign w_sub = 18'd14 + {12'd0, w_ihl, 2'b00} + (w_udp ? 18'd8 : 18'd20);
    assign w_pay = ({2'b00, w_flen} > w_sub) ? 16'({2'b00, w_flen} - w_sub) : 16'd0;

    // retransmission decision from the matched entry
    assign w_diff = w_seq - w_nseq;
    assign w_keep = (r_pay <= 16'd1) && (w_syn || w_fin || w_rst) && (w_diff == '1);
    assign w_retx = !w_udp && w_sts.found && !w_keep &&
                    (r_pay != 16'd0 || w_syn || w_fin) && (w_nseq > w_seq);
    assign w_ins  = !w_retx && !w_sts.found && (r_used < CW'(FLOW_ENTRIES));

    // sequencer
    always_comb begin
        n_state = r_state;
        w_ctl.start = 1'b0;
        unique case (r_state)
            t_IDLE:   if (s_axis_tvalid) n_state = t_CHECK;
            t_CHECK: begin
                if ((w_proto == PROTO_TCP || w_udp) && w_track) begin
                    w_ctl.start = 1'b1;
                    n_state = t_SEARCH;
                end else begin
                    n_state = t_OUT;
                end
            end
            t_SEARCH: if (w_sts.done) n_state = t_DONE;
            t_DONE:   n_state = t_OUT;
            t_OUT:    if (m_axis_tready) n_state = t_IDLE;
            default:  n_state = t_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_IDLE;
            r_fen   <= 1'b0;
            r_fport <= '0;
            r_used  <= '0;
            r_tcp_p <= '0;
            r_udp_p <= '0;
            r_tcp_b <= '0;
            r_udp_b <= '0;
            r_tcp_f <= '0;
            r_udp_f <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_FILTER_ENABLE: r_fen   <= i_cfg_data[0];
                    REG_FILTER_PORT:   r_fport <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == t_CHECK) begin
                if (w_proto == PROTO_TCP) begin
                    r_tcp_p <= r_tcp_p + 32'd1;
                    r_tcp_b <= r_tcp_b + {16'd0, w_flen};
                end else if (w_udp) begin
                    r_udp_p <= r_udp_p + 32'd1;
                    r_udp_b <= r_udp_b + {16'd0, w_flen};
                end
            end
            if (r_state == t_DONE && w_ins) begin
                r_used <= r_used + 1'b1;
                if (w_udp) r_udp_f <= r_udp_f + 9'd1;
                else       r_tcp_f <= r_tcp_f + 9'd1;
            end
        end
        if (r_state == t_IDLE) r_in <= s_axis_tdata;
        if (r_state == t_CHECK) begin
            r_kind <= (w_proto == PROTO_TCP) ? KIND_TCP : (w_udp ? KIND_UDP : KIND_OTHER);
            r_pay  <= (w_proto == PROTO_TCP || w_udp) ? w_pay : 16'd0;
            r_pass <= (w_proto == PROTO_TCP || w_udp) && w_track;
            r_retx <= 1'b0;
            r_new  <= 1'b0;
            r_full <= 1'b0;
        end
        if (r_state == t_DONE) begin
            r_retx <= w_retx;
            r_new  <= w_ins;
            r_full <= !w_retx && !w_sts.found && !w_ins;
        end
    end

    ftrt_ram #(.WIDTH(ENTRY_W), .DEPTH(FLOW_ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == t_DONE && w_ins),
        .i_waddr (r_used[AW-1:0]),
        .i_wdata ({w_key, w_udp ? 32'd0 : w_seq + {16'd0, r_pay}}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ftrt_search #(.AW(AW), .CW(CW)) u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_key      (w_key),
        .i_used     (r_used),
        .i_rdata    (w_rdata),
        .o_raddr    (w_raddr),
        .o_sts      (w_sts),
        .o_next_seq (w_nseq)
    );

    assign s_axis_tready = (r_state == t_IDLE);
    assign m_axis_tvalid = (r_state == t_OUT);
    assign m_axis_tdata  = {8'd0, r_udp_f, r_tcp_f, r_udp_b, r_tcp_b, r_udp_p, r_tcp_p,
                            r_pay, r_full, r_new, r_retx, r_pass, r_kind};

    `include "assert_macros.svh"
    `ASSERT_CLK(a_used_max, i_clk, i_rst_n, r_used <= CW'(FLOW_ENTRIES), "table overflow")
    `ASSERT_CLK(a_one_flag, i_clk, i_rst_n,
        m_axis_tvalid |-> !(r_new && (r_full || r_retx)), "conflicting flags")
    `ASSERT_CLK(a_flows, i_clk, i_rst_n,
        r_state == t_IDLE |-> (CW+1)'(r_used) == (CW+1)'(r_tcp_f + r_udp_f), "flow count")
endmodule
